@@ design/lfu_pkg.sv @@
// Shared types, constants and codes of the LFU cache.
package lfu_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_W           = 5;
   localparam int KEY_W           = 32;
   localparam int DATA_W          = 32;
   localparam int COUNT_W         = 32;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic                     command;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // What the update sweep does to each entry
   typedef struct packed {
      logic touch;
      logic evict;
      logic insert;
      logic put;
   } act_type;

endpackage

@@ design/lfu_store.sv @@
// Entry memory: key, data, use count and recency rank, one read and one write port.
module lfu_store #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = 4
) (
   input  logic                             clock,
   input  logic [IDX_W-1:0]                 rd_addr,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic signed [lfu_pkg::KEY_W-1:0] wr_key,
   input  logic signed [lfu_pkg::DATA_W-1:0] wr_data,
   input  logic [lfu_pkg::COUNT_W-1:0]      wr_count,
   input  logic [IDX_W-1:0]                 wr_rank,
   output logic signed [lfu_pkg::KEY_W-1:0] rd_key,
   output logic signed [lfu_pkg::DATA_W-1:0] rd_data,
   output logic [lfu_pkg::COUNT_W-1:0]      rd_count,
   output logic [IDX_W-1:0]                 rd_rank
);

   logic signed [lfu_pkg::KEY_W-1:0]  key_mem   [ENTRIES];
   logic signed [lfu_pkg::DATA_W-1:0] data_mem  [ENTRIES];
   logic [lfu_pkg::COUNT_W-1:0]       count_mem [ENTRIES];
   logic [IDX_W-1:0]                  rank_mem  [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         data_mem[wr_addr]  <= wr_data;
         count_mem[wr_addr] <= wr_count;
         rank_mem[wr_addr]  <= wr_rank;
      end
   end

   always_ff @(posedge clock) begin
      rd_key   <= key_mem[rd_addr];
      rd_data  <= data_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
      rd_rank  <= rank_mem[rd_addr];
   end

endmodule

@@ design/lfu_unit.sv @@
// Per-entry compare and update unit, shared by the scan and update sweeps.
module lfu_unit #(
   parameter int IDX_W = 4
) (
   input  logic                               e_valid,
   input  logic [IDX_W-1:0]                   e_idx,
   input  logic signed [lfu_pkg::KEY_W-1:0]   e_key,
   input  logic signed [lfu_pkg::DATA_W-1:0]  e_data,
   input  logic [lfu_pkg::COUNT_W-1:0]        e_count,
   input  logic [IDX_W-1:0]                   e_rank,
   input  logic signed [lfu_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lfu_pkg::DATA_W-1:0]  req_value,
   input  logic                               vic_found,
   input  logic [IDX_W-1:0]                   vic_idx,
   input  logic [lfu_pkg::COUNT_W-1:0]        vic_count,
   input  logic [IDX_W-1:0]                   vic_rank,
   input  logic [IDX_W-1:0]                   match_idx,
   input  logic [IDX_W-1:0]                   match_rank,
   input  logic [IDX_W-1:0]                   ins_idx,
   input  lfu_pkg::act_type                   act,
   output logic                               is_match,
   output logic                               is_better,
   output logic                               new_valid,
   output logic signed [lfu_pkg::KEY_W-1:0]   new_key,
   output logic signed [lfu_pkg::DATA_W-1:0]  new_data,
   output logic [lfu_pkg::COUNT_W-1:0]        new_count,
   output logic [IDX_W-1:0]                   new_rank
);

   logic dec;
   logic is_victim;
   logic is_ins;

   assign is_match  = e_valid && (e_key == req_key);
   // Lower count wins; on equal counts the older entry wins
   assign is_better = e_valid && (!vic_found || (e_count < vic_count) ||
                                  ((e_count == vic_count) && (e_rank > vic_rank)));

   assign is_victim = act.evict && (e_idx == vic_idx);
   assign is_ins    = act.insert && (e_idx == ins_idx);
   assign dec       = act.evict && (e_rank > vic_rank);

   always_comb begin
      new_valid = e_valid;
      new_key   = e_key;
      new_data  = e_data;
      new_count = e_count;
      new_rank  = e_rank;
      if (act.touch) begin
         if (e_idx == match_idx) begin
            new_rank  = '0;
            new_count = (e_count == lfu_pkg::COUNT_MAX) ? e_count
                                                        : e_count + lfu_pkg::COUNT_W'(1);
            if (act.put) begin
               new_data = req_value;
            end
         end else if (e_valid && (e_rank < match_rank)) begin
            new_rank = e_rank + IDX_W'(1);
         end
      end else begin
         if (is_victim) begin
            new_valid = 1'b0;
         end else if (e_valid) begin
            new_rank = e_rank + IDX_W'(act.insert) - IDX_W'(dec);
         end
         if (is_ins) begin
            new_valid = 1'b1;
            new_key   = req_key;
            new_data  = req_value;
            new_count = lfu_pkg::COUNT_W'(1);
            new_rank  = '0;
         end
      end
   end

endmodule

@@ design/lfu_ctrl.sv @@
// Sequencer: scan sweep, decision, update sweep and result register.
module lfu_ctrl #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = 4,
   parameter int OCC_W   = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lfu_pkg::CAP_W-1:0]   capacity,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lfu_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lfu_pkg::rsp_type            rsp_data
);

   lfu_pkg::state_type state_ff, state_in;
   logic [OCC_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               rsp_valid_ff, rsp_valid_in;

   lfu_pkg::req_type   req_ff, req_in;
   logic [OCC_W-1:0]   cap_ff, cap_in;
   logic               match_found_ff, match_found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]   match_rank_ff, match_rank_in;
   logic signed [lfu_pkg::DATA_W-1:0] match_data_ff, match_data_in;
   logic               vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]   vic_idx_ff, vic_idx_in;
   logic [lfu_pkg::COUNT_W-1:0] vic_count_ff, vic_count_in;
   logic [IDX_W-1:0]   vic_rank_ff, vic_rank_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   lfu_pkg::act_type   act_ff, act_in;
   logic [IDX_W-1:0]   ins_idx_ff, ins_idx_in;
   lfu_pkg::rsp_type   res_ff, res_in;
   lfu_pkg::rsp_type   rsp_ff, rsp_in;

   logic               issuing;
   logic               e_valid;
   logic               do_put;
   logic               ev;
   logic               load;
   logic               wr_en;

   logic signed [lfu_pkg::KEY_W-1:0]  rd_key, new_key;
   logic signed [lfu_pkg::DATA_W-1:0] rd_data, new_data;
   logic [lfu_pkg::COUNT_W-1:0]       rd_count, new_count;
   logic [IDX_W-1:0]                  rd_rank, new_rank;
   logic                              is_match, is_better, new_valid;

   assign issuing = ((state_ff == lfu_pkg::ST_SCAN) || (state_ff == lfu_pkg::ST_UPDATE)) &&
                    (cnt_ff != OCC_W'(ENTRIES));
   assign e_valid = valid_ff[pidx_ff];
   assign wr_en   = pend_ff && (state_ff == lfu_pkg::ST_UPDATE);
   assign do_put  = (req_ff.command == lfu_pkg::CMD_PUT) && (cap_ff != '0);
   assign ev      = do_put && !match_found_ff && (occ_ff >= cap_ff);

   lfu_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock    (clock),
      .rd_addr  (cnt_ff[IDX_W-1:0]),
      .wr_en    (wr_en),
      .wr_addr  (pidx_ff),
      .wr_key   (new_key),
      .wr_data  (new_data),
      .wr_count (new_count),
      .wr_rank  (new_rank),
      .rd_key   (rd_key),
      .rd_data  (rd_data),
      .rd_count (rd_count),
      .rd_rank  (rd_rank)
   );

   lfu_unit #(
      .IDX_W (IDX_W)
   ) u_unit (
      .e_valid    (e_valid),
      .e_idx      (pidx_ff),
      .e_key      (rd_key),
      .e_data     (rd_data),
      .e_count    (rd_count),
      .e_rank     (rd_rank),
      .req_key    (req_ff.key),
      .req_value  (req_ff.value),
      .vic_found  (vic_found_ff),
      .vic_idx    (vic_idx_ff),
      .vic_count  (vic_count_ff),
      .vic_rank   (vic_rank_ff),
      .match_idx  (match_idx_ff),
      .match_rank (match_rank_ff),
      .ins_idx    (ins_idx_ff),
      .act        (act_ff),
      .is_match   (is_match),
      .is_better  (is_better),
      .new_valid  (new_valid),
      .new_key    (new_key),
      .new_data   (new_data),
      .new_count  (new_count),
      .new_rank   (new_rank)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = issuing ? cnt_ff + OCC_W'(1) : cnt_ff;
      pend_in        = issuing;
      pidx_in        = cnt_ff[IDX_W-1:0];
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      req_in         = req_ff;
      cap_in         = cap_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_rank_in  = match_rank_ff;
      match_data_in  = match_data_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_count_in   = vic_count_ff;
      vic_rank_in    = vic_rank_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      act_in         = act_ff;
      ins_idx_in     = ins_idx_ff;
      res_in         = res_ff;
      load           = 1'b0;
      req_stall      = (state_ff != lfu_pkg::ST_IDLE);

      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in         = req_data;
               cap_in         = (32'(capacity) > 32'(ENTRIES)) ? OCC_W'(ENTRIES)
                                                               : OCC_W'(capacity);
               match_found_in = 1'b0;
               vic_found_in   = 1'b0;
               free_found_in  = 1'b0;
               cnt_in         = '0;
               state_in       = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (pend_ff) begin
               if (is_match && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = pidx_ff;
                  match_rank_in  = rd_rank;
                  match_data_in  = rd_data;
               end
               if (is_better) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = pidx_ff;
                  vic_count_in = rd_count;
                  vic_rank_in  = rd_rank;
               end
               if (!e_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pidx_ff;
               end
            end
            if (!issuing) begin
               state_in = lfu_pkg::ST_DECIDE;
            end
         end
         lfu_pkg::ST_DECIDE: begin
            act_in.put    = do_put;
            act_in.touch  = match_found_ff &&
                            ((req_ff.command == lfu_pkg::CMD_GET) || do_put);
            act_in.evict  = ev && vic_found_ff;
            act_in.insert = do_put && !match_found_ff && (free_found_ff || act_in.evict);
            // Fill the lowest free slot; the victim's slot counts as free
            ins_idx_in = (act_in.evict && !(free_found_ff && (free_idx_ff < vic_idx_ff)))
                         ? vic_idx_ff : free_idx_ff;
            occ_in = occ_ff - OCC_W'(act_in.evict && (occ_ff != '0)) +
                     OCC_W'(act_in.insert);
            res_in.hit        = match_found_ff;
            res_in.read_value = (match_found_ff && (req_ff.command == lfu_pkg::CMD_GET))
                                ? match_data_ff : '0;
            res_in.evicted    = ev;
            cnt_in            = '0;
            state_in = (act_in.touch || act_in.evict || act_in.insert) ? lfu_pkg::ST_UPDATE
                                                                       : lfu_pkg::ST_FINISH;
         end
         lfu_pkg::ST_UPDATE: begin
            if (pend_ff) begin
               valid_in[pidx_ff] = new_valid;
            end
            if (!issuing) begin
               state_in = lfu_pkg::ST_FINISH;
            end
         end
         lfu_pkg::ST_FINISH: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_in       = load ? res_ff : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      req_ff         <= req_in;
      cap_ff         <= cap_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_rank_ff  <= match_rank_in;
      match_data_ff  <= match_data_in;
      vic_found_ff   <= vic_found_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      act_ff         <= act_in;
      ins_idx_ff     <= ins_idx_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/lfu_cache_replacement.sv @@
// Top level of the LFU cache with least-recently-used tie break.
//
//  Channel | Direction | Handshake              | Payload
//  req_    | in        | req_valid / req_stall  | lfu_pkg::req_type (command, key, value)
//  rsp_    | out       | rsp_valid / rsp_stall  | lfu_pkg::rsp_type (hit, read_value, evicted)
//  csr_    | in        | csr_valid / csr_ready  | capacity, 5 bits
//
// A request sweeps the entry memory, with its one read and one write port, one entry
// a cycle to scan and, when it changes an entry, again to update.
// Reset is synchronous; it empties the cache and sets capacity to sixteen, with no
// clearing pass. A finished result waits in the output register while the next
// request is taken; a stalled result holds the sequencer in its last step.
module lfu_cache_replacement #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lfu_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lfu_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0] csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic [lfu_pkg::CAP_W-1:0] capacity_ff, capacity_in;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfu_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lfu_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .OCC_W   (OCC_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/lfu_checker.sv @@
// Port-level checks on the LFU cache and their binding to the top level.
module lfu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lfu_pkg::rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // One request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // An eviction only follows a put miss, so no value is read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit && (rsp_data.read_value == '0))
      else $error("eviction on hit or with read data");

   // A miss returns no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == '0)
      else $error("miss returned data");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
